// ===== rtl/core/hsp_pkg.sv =====
package hsp_pkg;

  localparam int FRAC_BITS = 8;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int MAX_KNOTS = 1024;
  localparam int KNOT_AW   = $clog2(MAX_KNOTS);
  localparam int COORD_W   = 16;
  localparam int WEIGHT_W  = 18;
  localparam int SET_W     = 13;

  typedef enum logic [2:0] {
    REG_TENSION    = 3'd0,
    REG_CONTINUITY = 3'd1,
    REG_BIAS       = 3'd2,
    REG_CLOSED     = 3'd3,
    REG_KNOT_COUNT = 3'd4,
    REG_STEPS      = 3'd5
  } reg_idx_t;

  // tangent weights: din c1, din c2, dout c1, dout c2
  typedef struct packed {
    logic signed [WEIGHT_W-1:0] k0;
    logic signed [WEIGHT_W-1:0] k1;
    logic signed [WEIGHT_W-1:0] k2;
    logic signed [WEIGHT_W-1:0] k3;
  } weights_t;

  // setting / 5 in fixed point, rounded then truncated toward zero
  // (v*65536 + 640) / 1280 reduces to (512*v + 5) / 10, done on the magnitude
  // with a reciprocal multiply
  function automatic logic signed [SET_W-1:0] scale_fifth(input logic signed [5:0] v);
    logic signed [15:0] num;
    logic [15:0]        mag;
    logic [35:0]        prod;
    logic [SET_W-1:0]   q;
    num  = 16'(v) * 16'(2 * ONE) + 16'sd5;
    mag  = (num < 0) ? 16'(-num) : 16'(num);
    prod = 36'(mag) * 36'd52429;
    q    = prod[19+SET_W-1:19];
    return (num < 0) ? -$signed(q) : $signed(q);
  endfunction

endpackage

// ===== rtl/core/tcb_hermite_spline_point.sv =====
// Hermite spline point unit (tension/continuity/bias). A load request (opcode 0)
// writes one knot into the knot memory and does not raise busy. An evaluate
// request (opcode 1) reads the single-port knot memory once for each of the
// four neighbouring knots, so busy stays high while the last three are read
// and no new request is taken before the reads are done.
// The result shows on point_x/point_y/bad_request with done high for one cycle;
// the receiver cannot stall, so results must be taken as they come. After
// reset and after every register write the tangent weights are recomputed and
// busy stays high until they have settled. Knots must be loaded before any
// evaluation reads them; the memory is not cleared.
module tcb_hermite_spline_point (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [9:0]  knot_index,
  input  logic signed [15:0] knot_x,
  input  logic signed [15:0] knot_y,
  input  logic [9:0]  segment,
  input  logic [6:0]  step,
  // result channel
  output logic        done,
  output logic signed [15:0] point_x,
  output logic signed [15:0] point_y,
  output logic        bad_request
);

  localparam int AW = hsp_pkg::KNOT_AW;
  localparam int CW = hsp_pkg::COORD_W;
  localparam int WW = hsp_pkg::WEIGHT_W;

  // configuration registers
  logic signed [5:0] tension, continuity, bias_setting;
  logic              loop_closed;
  logic [10:0]       knot_count;
  logic [6:0]        steps_per_segment;
  logic [2:0]        wcnt;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tension           <= '0;
      continuity        <= '0;
      bias_setting      <= '0;
      loop_closed       <= 1'b0;
      knot_count        <= 11'd2;
      steps_per_segment <= 7'd16;
    end else if (cfg_wr) begin
      case (hsp_pkg::reg_idx_t'(paddr[4:2]))
        hsp_pkg::REG_TENSION:    tension           <= pwdata[5:0];
        hsp_pkg::REG_CONTINUITY: continuity        <= pwdata[5:0];
        hsp_pkg::REG_BIAS:       bias_setting      <= pwdata[5:0];
        hsp_pkg::REG_CLOSED:     loop_closed       <= pwdata[0];
        hsp_pkg::REG_KNOT_COUNT: knot_count        <= pwdata[10:0];
        hsp_pkg::REG_STEPS:      steps_per_segment <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (hsp_pkg::reg_idx_t'(paddr[4:2]))
      hsp_pkg::REG_TENSION:    prdata = 32'(unsigned'(tension));
      hsp_pkg::REG_CONTINUITY: prdata = 32'(unsigned'(continuity));
      hsp_pkg::REG_BIAS:       prdata = 32'(unsigned'(bias_setting));
      hsp_pkg::REG_CLOSED:     prdata = 32'(loop_closed);
      hsp_pkg::REG_KNOT_COUNT: prdata = 32'(knot_count);
      hsp_pkg::REG_STEPS:      prdata = 32'(steps_per_segment);
      default:                 prdata = '0;
    endcase
  end

  // busy is held while the weight pipeline settles after any settings change
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) wcnt <= 3'd4;
    else if (wcnt != 3'd0) wcnt <= wcnt - 3'd1;
  end

  hsp_pkg::weights_t kw;

  hsp_weights u_weights (
    .clk          (clk),
    .tension      (tension),
    .continuity   (continuity),
    .bias_setting (bias_setting),
    .kw           (kw)
  );

  // request decode
  logic        active;
  logic [1:0]  ph;
  logic        accept, acc_eval, acc_load;
  logic [10:0] n_eff, seg_last, segs, nx11, n211;
  logic [6:0]  steps_eff;
  logic [AW-1:0] nx_w, pv_w, n2_w;
  logic        in_bad, za_w, zb_w;

  assign busy     = active | (wcnt != 3'd0);
  assign accept   = start & ~busy;
  assign acc_eval = accept & opcode;
  assign acc_load = accept & ~opcode;

  always_comb begin
    // clamp knot count to 2..MAX_KNOTS, zero steps acts as one
    if (knot_count < 11'd2)                             n_eff = 11'd2;
    else if (knot_count > 11'(hsp_pkg::MAX_KNOTS))      n_eff = 11'(hsp_pkg::MAX_KNOTS);
    else                                                n_eff = knot_count;
    steps_eff = (steps_per_segment == 7'd0) ? 7'd1 : steps_per_segment;
    seg_last  = n_eff - 11'd1;
    segs      = seg_last + 11'(loop_closed);
    in_bad    = ({1'b0, segment} >= segs) || (step > steps_eff);
    nx11      = {1'b0, segment} + 11'd1;
    nx_w      = (nx11 == n_eff) ? '0 : nx11[AW-1:0];
    n211      = {1'b0, nx_w} + 11'd1;
    n2_w      = (n211 == n_eff) ? '0 : n211[AW-1:0];
    pv_w      = (segment == '0) ? seg_last[AW-1:0] : segment - 10'd1;
    // open curve: end knots have tension one, so their weights vanish
    za_w      = ~loop_closed & ((segment == '0) || ({1'b0, segment} == seg_last));
    zb_w      = ~loop_closed & ((nx_w == '0) || ({1'b0, nx_w} == seg_last));
  end

  // knot memory, x in the upper half, y in the lower half
  logic [2*CW-1:0] knot_mem [hsp_pkg::MAX_KNOTS];
  logic [2*CW-1:0] mem_q;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   idx_a, idx_nx, idx_n2;

  always_comb begin
    if (acc_eval) raddr = pv_w;
    else begin
      case (ph)
        2'd1:    raddr = idx_a;
        2'd2:    raddr = idx_nx;
        default: raddr = idx_n2;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc_load) knot_mem[knot_index] <= {knot_x, knot_y};
    else          mem_q <= knot_mem[raddr];
  end

  // read sequencer: previous knot at accept, then segment start, end, next
  logic       rvalid;
  logic [1:0] rph;
  logic       lvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ph     <= 2'd0;
      rvalid <= 1'b0;
      rph    <= 2'd0;
      lvalid <= 1'b0;
    end else begin
      lvalid <= rvalid && (rph == 2'd3);
      if (acc_eval) begin
        active <= 1'b1;
        ph     <= 2'd1;
        rvalid <= 1'b1;
        rph    <= 2'd0;
      end else if (active) begin
        rvalid <= 1'b1;
        rph    <= ph;
        ph     <= ph + 2'd1;
        if (ph == 2'd3) active <= 1'b0;
      end else begin
        rvalid <= 1'b0;
      end
    end
  end

  // per-request context, held until launch
  logic it_za, it_zb, it_bad;
  logic [16:0] drem, drem_n;
  logic [8:0]  dq, dq_n;
  logic [7:0]  dden;
  logic [3:0]  dbase;

  // s = floor((512*step + steps) / (2*steps)), three quotient bits a cycle
  always_comb begin
    logic [16:0] sub;
    int k;
    drem_n = drem;
    dq_n   = dq;
    case (ph)
      2'd1:    dbase = 4'd6;
      2'd2:    dbase = 4'd3;
      default: dbase = 4'd0;
    endcase
    for (int j = 0; j < 3; j++) begin
      k   = int'(dbase) + 2 - j;
      sub = 17'(dden) << k;
      if (drem_n >= sub) begin
        drem_n = drem_n - sub;
        dq_n   = dq_n | (9'd1 << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_eval) begin
      idx_a  <= segment;
      idx_nx <= nx_w;
      idx_n2 <= n2_w;
      it_za  <= za_w;
      it_zb  <= zb_w;
      it_bad <= in_bad;
      drem   <= 17'({step, 9'd0}) + 17'(steps_eff);
      dq     <= '0;
      dden   <= {steps_eff, 1'b0};
    end else if (active) begin
      drem <= drem_n;
      dq   <= dq_n;
    end
  end

  // knots gathered for the request, [coord][0..2]; coord 0 is x, 1 is y
  logic signed [CW-1:0] kp [2][3];

  always_ff @(posedge clk) begin
    if (rvalid && rph != 2'd3) begin
      kp[0][rph] <= mem_q[2*CW-1:CW];
      kp[1][rph] <= mem_q[CW-1:0];
    end
  end

  // launch stage
  logic signed [CW-1:0] l_p [2][4];
  logic [8:0] l_s;
  logic l_za, l_zb, l_bad;

  always_ff @(posedge clk) begin
    if (rvalid && rph == 2'd3) begin
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < 3; i++) l_p[c][i] <= kp[c][i];
      end
      l_p[0][3] <= mem_q[2*CW-1:CW];
      l_p[1][3] <= mem_q[CW-1:0];
      l_s   <= dq;
      l_za  <= it_za;
      l_zb  <= it_zb;
      l_bad <= it_bad;
    end
  end

  // stage 1: knot differences times tangent weights, s squared
  logic signed [WW-1:0] ka2, ka3, kb0, kb1;
  logic signed [16:0]   d10 [2], d21 [2], d32 [2];
  logic [17:0]          sq;

  always_comb begin
    ka2 = l_za ? '0 : kw.k2;
    ka3 = l_za ? '0 : kw.k3;
    kb0 = l_zb ? '0 : kw.k0;
    kb1 = l_zb ? '0 : kw.k1;
    for (int c = 0; c < 2; c++) begin
      d10[c] = 17'(l_p[c][1]) - 17'(l_p[c][0]);
      d21[c] = 17'(l_p[c][2]) - 17'(l_p[c][1]);
      d32[c] = 17'(l_p[c][3]) - 17'(l_p[c][2]);
    end
    sq = 18'(l_s) * 18'(l_s);
  end

  logic                 s1_v, s1_bad;
  logic [8:0]           s1_s, s1_s2;
  logic signed [34:0]   s1_pr [2][4];
  logic signed [CW-1:0] s1_p1 [2], s1_p2 [2];

  always_ff @(posedge clk) begin
    s1_s   <= l_s;
    s1_s2  <= sq[16:8];
    s1_bad <= l_bad;
    for (int c = 0; c < 2; c++) begin
      s1_pr[c][0] <= 35'(d10[c]) * 35'(ka2);
      s1_pr[c][1] <= 35'(d21[c]) * 35'(ka3);
      s1_pr[c][2] <= 35'(d21[c]) * 35'(kb0);
      s1_pr[c][3] <= 35'(d32[c]) * 35'(kb1);
      s1_p1[c]    <= l_p[c][1];
      s1_p2[c]    <= l_p[c][2];
    end
  end

  // stage 2: tangents, s cubed
  logic [17:0]          cu;
  logic                 s2_v, s2_bad;
  logic [8:0]           s2_s, s2_s2, s2_s3;
  logic signed [35:0]   s2_tout [2], s2_tin [2];
  logic signed [CW-1:0] s2_p1 [2], s2_p2 [2];

  assign cu = 18'(s1_s2) * 18'(s1_s);

  always_ff @(posedge clk) begin
    s2_s   <= s1_s;
    s2_s2  <= s1_s2;
    s2_s3  <= cu[16:8];
    s2_bad <= s1_bad;
    for (int c = 0; c < 2; c++) begin
      s2_tout[c] <= 36'(s1_pr[c][0]) + 36'(s1_pr[c][1]);
      s2_tin[c]  <= 36'(s1_pr[c][2]) + 36'(s1_pr[c][3]);
      s2_p1[c]   <= s1_p1[c];
      s2_p2[c]   <= s1_p2[c];
    end
  end

  // stage 3: hermite basis
  logic signed [11:0] bs, bs2, bs3;
  logic                 s3_v, s3_bad;
  logic signed [11:0]   s3_h0, s3_h1, s3_h2, s3_h3;
  logic signed [35:0]   s3_tout [2], s3_tin [2];
  logic signed [CW-1:0] s3_p1 [2], s3_p2 [2];

  always_comb begin
    bs  = $signed({3'b000, s2_s});
    bs2 = $signed({3'b000, s2_s2});
    bs3 = $signed({3'b000, s2_s3});
  end

  always_ff @(posedge clk) begin
    s3_h0   <= 12'sd2 * bs3 - 12'sd3 * bs2 + 12'(hsp_pkg::ONE);
    s3_h1   <= 12'sd3 * bs2 - 12'sd2 * bs3;
    s3_h2   <= bs3 - 12'sd2 * bs2 + bs;
    s3_h3   <= bs3 - bs2;
    s3_bad  <= s2_bad;
    s3_tout <= s2_tout;
    s3_tin  <= s2_tin;
    s3_p1   <= s2_p1;
    s3_p2   <= s2_p2;
  end

  // stage 4: basis times points and tangents
  logic signed [47:0]   tm2 [2], tm3 [2];
  logic                 s4_v, s4_bad;
  logic signed [27:0]   s4_m0 [2], s4_m1 [2];
  logic signed [39:0]   s4_m2 [2], s4_m3 [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      tm2[c] = 48'(s3_h2) * 48'(s3_tout[c]);
      tm3[c] = 48'(s3_h3) * 48'(s3_tin[c]);
    end
  end

  always_ff @(posedge clk) begin
    s4_bad <= s3_bad;
    for (int c = 0; c < 2; c++) begin
      // knot terms are exact: FIX(p) times basis, scaled back
      s4_m0[c] <= 28'(s3_h0) * 28'(s3_p1[c]);
      s4_m1[c] <= 28'(s3_h1) * 28'(s3_p2[c]);
      s4_m2[c] <= tm2[c][47:8];
      s4_m3[c] <= tm3[c][47:8];
    end
  end

  // stage 5: sum, floor, saturate
  logic signed [40:0] psum [2];
  logic signed [32:0] pfl [2];
  logic signed [CW-1:0] psat [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      psum[c] = 41'(s4_m0[c]) + 41'(s4_m1[c]) + 41'(s4_m2[c]) + 41'(s4_m3[c]);
      pfl[c]  = psum[c][40:8];
      if (pfl[c] > 33'sd32767)       psat[c] = 16'sh7fff;
      else if (pfl[c] < -33'sd32768) psat[c] = 16'sh8000;
      else                           psat[c] = pfl[c][15:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v <= lvalid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      done <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    bad_request <= s4_bad;
    point_x     <= s4_bad ? '0 : psat[0];
    point_y     <= s4_bad ? '0 : psat[1];
  end

endmodule

// ===== rtl/core/hsp_weights.sv =====
module hsp_weights (
  input  logic                clk,
  input  logic signed [5:0]   tension,
  input  logic signed [5:0]   continuity,
  input  logic signed [5:0]   bias_setting,
  output hsp_pkg::weights_t   kw
);

  logic signed [hsp_pkg::SET_W-1:0] t, c, b;
  logic signed [19:0] tc1, tc2;
  logic signed [13:0] opb, omb;
  logic signed [25:0] x0, x1, x2, x3;

  logic signed [13:0] omt, opc, omc;
  logic signed [27:0] pr1, pr2;
  logic signed [33:0] q0, q1, q2, q3;

  function automatic logic signed [hsp_pkg::WEIGHT_W-1:0] half_round(
      input logic signed [25:0] x);
    logic signed [26:0] y;
    logic signed [26:0] r;
    y = 27'(x) + 27'sd1;
    if (y < 0) r = -((-y) >>> 1);
    else       r = y >>> 1;
    return r[hsp_pkg::WEIGHT_W-1:0];
  endfunction

  always_comb begin
    omt = 14'(hsp_pkg::ONE) - 14'(t);
    opc = 14'(hsp_pkg::ONE) + 14'(c);
    omc = 14'(hsp_pkg::ONE) - 14'(c);
    pr1 = 28'(omt) * 28'(omc);
    pr2 = 28'(omt) * 28'(opc);
    q0  = 34'(tc1) * 34'(opb);
    q1  = 34'(tc2) * 34'(omb);
    q2  = 34'(tc2) * 34'(opb);
    q3  = 34'(tc1) * 34'(omb);
  end

  // four-stage pipeline, free running on the settings
  always_ff @(posedge clk) begin
    t   <= hsp_pkg::scale_fifth(tension);
    c   <= hsp_pkg::scale_fifth(continuity);
    b   <= hsp_pkg::scale_fifth(bias_setting);
    tc1 <= pr1[27:8];
    tc2 <= pr2[27:8];
    opb <= 14'(hsp_pkg::ONE) + 14'(b);
    omb <= 14'(hsp_pkg::ONE) - 14'(b);
    x0  <= q0[33:8];
    x1  <= q1[33:8];
    x2  <= q2[33:8];
    x3  <= q3[33:8];
    kw.k0 <= half_round(x0);
    kw.k1 <= half_round(x1);
    kw.k2 <= half_round(x2);
    kw.k3 <= half_round(x3);
  end

endmodule

// ===== rtl/core/hsp_checker.sv =====
module hsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        opcode,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic        done,
  input logic        bad_request,
  input logic signed [15:0] point_x,
  input logic signed [15:0] point_y
);

  // an evaluate request holds off the next one
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode) |=> busy)
    else $error("busy low after evaluate request");

  // weights are rebuilt after a register write
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) |=> busy)
    else $error("busy low after register write");

  // results are spaced by the memory read sequence
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results in adjacent cycles");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_request) |-> (point_x == 16'sd0 && point_y == 16'sd0))
    else $error("bad request with nonzero point");

endmodule

bind tcb_hermite_spline_point hsp_checker u_hsp_checker (.*);

// ===== bench/tcb_hermite_spline_point_check.sv =====
`timescale 1ns / 1ps

module tcb_hermite_spline_point_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        start,
  input  logic        busy,
  input  logic        opcode,
  input  logic [9:0]  knot_index,
  input  logic signed [15:0] knot_x,
  input  logic signed [15:0] knot_y,
  input  logic [9:0]  segment,
  input  logic [6:0]  step,
  input  logic        done,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic        bad_request,
  output int          fail_count,
  output int          points_pending
);

  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               bad;
  } point_t;

  localparam longint FONE = 256;

  point_t point_q[$];
  logic signed [15:0] xs [hsp_pkg::MAX_KNOTS];
  logic signed [15:0] ys [hsp_pkg::MAX_KNOTS];
  logic [5:0]  r_ten, r_con, r_bia;
  logic        r_closed;
  logic [10:0] r_count;
  logic [6:0]  r_steps;

  assign points_pending = point_q.size();

  function automatic longint floor_shr(longint v);
    return v >>> hsp_pkg::FRAC_BITS;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return floor_shr(a * b);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    return (a * FONE + b / 2) / b;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic tangent_weights(input longint t, input longint c, input longint b,
                                 output longint k[4]);
    longint tc1, tc2;
    tc1 = fx_mul(FONE - t, FONE - c);
    tc2 = fx_mul(FONE - t, FONE + c);
    k[0] = fx_div(fx_mul(tc1, FONE + b), 2 * FONE);
    k[1] = fx_div(fx_mul(tc2, FONE - b), 2 * FONE);
    k[2] = fx_div(fx_mul(tc2, FONE + b), 2 * FONE);
    k[3] = fx_div(fx_mul(tc1, FONE - b), 2 * FONE);
  endtask

  function automatic longint curve_coord(longint q0, longint q1, longint q2, longint q3,
                                         longint ka[4], longint kb[4], longint h[4]);
    longint p0, p1, p2, p3, dout, din, sum;
    p0 = q0 * FONE; p1 = q1 * FONE; p2 = q2 * FONE; p3 = q3 * FONE;
    dout = fx_mul(p1 - p0, ka[2]) + fx_mul(p2 - p1, ka[3]);
    din  = fx_mul(p2 - p1, kb[0]) + fx_mul(p3 - p2, kb[1]);
    sum = fx_mul(h[0], p1) + fx_mul(h[1], p2) + fx_mul(h[2], dout) + fx_mul(h[3], din);
    return clamp16(floor_shr(sum));
  endfunction

  task automatic predict_point(input logic [9:0] sg, input logic [6:0] st);
    longint n, steps, segs, a, nx, pv, n2, t, c, b, ta, tb, s, s2, s3;
    longint h[4], ka[4], kb[4];
    point_t p;
    n = r_count < 2 ? 2 : (r_count > hsp_pkg::MAX_KNOTS ? hsp_pkg::MAX_KNOTS : r_count);
    steps = r_steps == 0 ? 1 : r_steps;
    segs = n - 1 + r_closed;
    if (sg >= segs || st > steps) begin
      p.px = 0; p.py = 0; p.bad = 1;
      point_q.push_back(p);
      return;
    end
    a = sg;
    nx = (a + 1) % n;
    pv = a == 0 ? n - 1 : a - 1;
    n2 = (nx + 1) % n;
    t = fx_div(longint'($signed(r_ten)) * FONE, 5 * FONE);
    c = fx_div(longint'($signed(r_con)) * FONE, 5 * FONE);
    b = fx_div(longint'($signed(r_bia)) * FONE, 5 * FONE);
    ta = t; tb = t;
    if (!r_closed) begin
      if (a == 0 || a == n - 1) ta = FONE;
      if (nx == 0 || nx == n - 1) tb = FONE;
    end
    tangent_weights(ta, c, b, ka);
    tangent_weights(tb, c, b, kb);
    s = fx_div(longint'(st) * FONE, steps * FONE);
    s2 = fx_mul(s, s);
    s3 = fx_mul(s2, s);
    h[0] = fx_mul(2 * FONE, s3) - fx_mul(3 * FONE, s2) + FONE;
    h[1] = fx_mul(-2 * FONE, s3) + fx_mul(3 * FONE, s2);
    h[2] = s3 - fx_mul(2 * FONE, s2) + s;
    h[3] = s3 - s2;
    p.px = 16'(curve_coord(xs[pv], xs[a], xs[nx], xs[n2], ka, kb, h));
    p.py = 16'(curve_coord(ys[pv], ys[a], ys[nx], ys[n2], ka, kb, h));
    p.bad = 0;
    point_q.push_back(p);
  endtask

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      r_ten <= 0; r_con <= 0; r_bia <= 0; r_closed <= 0;
      r_count <= 2; r_steps <= 16;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (hsp_pkg::reg_idx_t'(paddr[4:2]))
          hsp_pkg::REG_TENSION:    r_ten    <= pwdata[5:0];
          hsp_pkg::REG_CONTINUITY: r_con    <= pwdata[5:0];
          hsp_pkg::REG_BIAS:       r_bia    <= pwdata[5:0];
          hsp_pkg::REG_CLOSED:     r_closed <= pwdata[0];
          hsp_pkg::REG_KNOT_COUNT: r_count  <= pwdata[10:0];
          hsp_pkg::REG_STEPS:      r_steps  <= pwdata[6:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (!opcode) begin
          xs[knot_index] = knot_x;
          ys[knot_index] = knot_y;
        end else begin
          predict_point(segment, step);
        end
      end
      if (done) begin
        if (point_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected point x=%0d y=%0d", point_x, point_y);
          fail_count <= fail_count + 1;
        end else begin
          e = point_q.pop_front();
          if (e.px !== point_x || e.py !== point_y || e.bad !== bad_request) begin
            if (fail_count < 10)
              $display("point mismatch: exp x=%0d y=%0d bad=%0b got x=%0d y=%0d bad=%0b",
                       e.px, e.py, e.bad, point_x, point_y, bad_request);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== bench/tcb_hermite_spline_point_test.sv =====
`timescale 1ns / 1ps

module tcb_hermite_spline_point_test;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready, busy, done, bad_request;
  logic start = 0, opcode = 0;
  logic [9:0] knot_index = 0, segment = 0;
  logic signed [15:0] knot_x = 0, knot_y = 0;
  logic [6:0] step = 0;
  logic signed [15:0] point_x, point_y;
  int fail_count, points_pending;

  // knots in use now; loads cover all of them before any evaluation
  int n_knots;
  int n_steps;
  bit closed;
  bit calm;

  always #6 clk = ~clk;

  tcb_hermite_spline_point dut (.*);
  tcb_hermite_spline_point_check chk (.*);

  // register write: setup then access cycle, written at access edge;
  // the caller ends the transfer
  task automatic write_reg(input hsp_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
  endtask

  // one request; random idle gaps ahead of it unless in the calm stretch
  // start stays high after the accepting edge, the next request or drain drops it
  task automatic send(input logic op, input logic [9:0] ki, input logic [15:0] kx,
                      input logic [15:0] ky, input logic [9:0] sg, input logic [6:0] st);
    if (!calm && $urandom_range(99) < 27) begin
      start <= 0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 27) @(posedge clk);
    end
    start <= 1; opcode <= op; knot_index <= ki; knot_x <= kx; knot_y <= ky;
    segment <= sg; step <= st;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_knots(input bit extreme);
    logic [15:0] vx, vy;
    for (int i = 0; i < n_knots; i++) begin
      vx = 16'($urandom); vy = 16'($urandom);
      if (extreme) begin
        vx = i[0] ? 16'h7fff : 16'h8000;
        vy = i[0] ? 16'h8000 : 16'h7fff;
      end
      send(0, 10'(i), vx, vy, 10'($urandom), 7'($urandom));
    end
  endtask

  // wait for every point, then allow the pipeline to drain before a write
  task automatic drain;
    start <= 0;
    while (points_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_curve(input int t, input int c, input int b, input bit cl,
                           input int n, input int s);
    drain();
    write_reg(hsp_pkg::REG_TENSION, 32'(t));
    write_reg(hsp_pkg::REG_CONTINUITY, 32'(c));
    write_reg(hsp_pkg::REG_BIAS, 32'(b));
    write_reg(hsp_pkg::REG_CLOSED, 32'(cl));
    write_reg(hsp_pkg::REG_KNOT_COUNT, 32'(n));
    write_reg(hsp_pkg::REG_STEPS, 32'(s));
    psel <= 0; penable <= 0; pwrite <= 0;
    closed = cl;
    n_knots = n < 2 ? 2 : (n > hsp_pkg::MAX_KNOTS ? hsp_pkg::MAX_KNOTS : n);
    n_steps = s == 0 ? 1 : s;
  endtask

  // mostly legal segment/step, some out of range
  task automatic eval_random;
    int segs;
    logic [9:0] sg;
    logic [6:0] st;
    segs = n_knots - 1 + closed;
    sg = 10'($urandom_range(segs - 1));
    st = 7'($urandom_range(n_steps > 127 ? 127 : n_steps));
    if ($urandom_range(9) == 0) sg = 10'($urandom);
    if ($urandom_range(9) == 0) st = 7'($urandom);
    if (sg >= n_knots && n_knots < hsp_pkg::MAX_KNOTS) sg = 10'(n_knots + $urandom_range(3));
    send(1, 10'($urandom), 16'($urandom), 16'($urandom), sg, st);
  endtask

  initial begin
    #50_000_000;
    $display("tcb_hermite_spline_point test failed");
    $finish;
  end

  initial begin
    int phase;
    calm = 0;
    closed = 0; n_knots = 2; n_steps = 16;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, extreme knots, endpoints, bad requests
    load_knots(1);
    send(1, 0, 0, 0, 0, 0);
    send(1, 0, 0, 0, 0, 16);
    send(1, 0, 0, 0, 0, 8);
    send(1, 0, 0, 0, 1, 0);
    send(1, 0, 0, 0, 0, 17);
    send(1, 0, 0, 0, 10'h3ff, 7'h7f);
    set_curve(-32, 31, -32, 1, 0, 0);
    send(1, 0, 0, 0, 0, 1);
    send(1, 0, 0, 0, 1, 0);
    send(1, 0, 0, 0, 2, 0);
    set_curve(20, -20, 20, 0, 3, 64);
    load_knots(1);
    send(1, 0, 0, 0, 1, 64);
    send(1, 0, 0, 0, 1, 33);
    send(1, 0, 0, 0, 0, 65);
    send(1, 10'h3ff, 16'h7fff, 16'h8000, 0, 0);

    // random phases, includes a larger store and odd settings
    for (phase = 0; phase < 12; phase++) begin
      int n, s;
      n = phase == 5 ? 300 : $urandom_range(2, 40);
      s = phase == 3 ? 127 : (phase == 9 ? 1 : $urandom_range(0, 64));
      set_curve($urandom_range(63), $urandom_range(63), $urandom_range(63),
                $urandom_range(1), n, s);
      load_knots($urandom_range(3) == 0);
      calm = phase == 6;
      repeat (42) eval_random();
      // reload of three knots after the evaluations of each phase
      repeat (3) send(0, 10'($urandom_range(n_knots - 1)), 16'($urandom), 16'($urandom), 0, 0);
      calm = 0;
    end

    drain();
    if (fail_count == 0)
      $display("tcb_hermite_spline_point test passed");
    else
      $display("tcb_hermite_spline_point test failed");
    $finish;
  end
endmodule
